FILE: rtl/vector_plane_projection_assert.svh
// Assertion macros shared by the projection RTL.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef VECTOR_PLANE_PROJECTION_ASSERT_SVH
`define VECTOR_PLANE_PROJECTION_ASSERT_SVH
`ifndef NO_ASSERTIONS
// expr must hold at every clock edge out of reset
`define VPP_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) else $error(msg);
// cons must hold in the same cycle as ante
`define VPP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// cons must hold in the cycle after ante
`define VPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VPP_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define VPP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define VPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/vpp_pkg.sv
// Package for the vector plane projection block: widths, item types and
// the restoring divide step. No dependencies.
package vpp_pkg;

    localparam int Q_W    = 32;   // Q16.16 component
    localparam int N_W    = 64;   // cross product component
    localparam int T_W    = 30;   // normalized normal magnitude
    localparam int S_W    = 6;    // normalization shift
    localparam int PR_W   = 63;   // v * n' product
    localparam int SQ_W   = 60;   // n'^2
    localparam int D_W    = 64;   // dot product v.n'
    localparam int DM_W   = 63;   // |v.n'|
    localparam int QS_W   = 62;   // n'.n'
    localparam int PL_W   = 62;   // low partial product
    localparam int PH_W   = 61;   // high partial product
    localparam int HALF_W = 32;   // split point of |d|
    localparam int NUM_W  = 93;   // dividend
    localparam int QUO_W  = 33;   // quotient bits produced
    localparam int REM_W  = 62;   // partial remainder
    localparam int C_W    = 34;   // rounded quotient
    localparam int SUM_W  = 36;   // final subtraction

    typedef logic signed [Q_W-1:0] t_q16;

    typedef struct packed {
        t_q16 vx;
        t_q16 vy;
        t_q16 vz;
        t_q16 ax;
        t_q16 ay;
        t_q16 az;
        t_q16 bx;
        t_q16 by;
        t_q16 bz;
    } t_in_item;

    typedef struct packed {
        t_q16 px;
        t_q16 py;
        t_q16 pz;
        logic degenerate;
    } t_out_item;

    // normalized normal plus the vector, after the front end
    typedef struct packed {
        logic [2:0][Q_W-1:0] v;
        logic [2:0][T_W-1:0] t;
        logic [2:0]          nneg;
        logic                degen;
    } t_ns_item;

    // one component's division job
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [QS_W-1:0]  q;
        logic [Q_W-1:0]   v;
        logic             neg;
        logic             degen;
    } t_div_in;

    // one divider pipeline stage
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] low;
        logic [QUO_W-1:0] quo;
        logic [QS_W-1:0]  q;
        logic [Q_W-1:0]   v;
        logic             neg;
        logic             degen;
    } t_div_stg;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    function automatic t_div_stg div_step(input t_div_stg x);
        logic [REM_W:0] r2;
        logic [REM_W:0] df;
        logic           ge;
        t_div_stg       y;
        r2 = {x.rem, x.low[QUO_W-1]};
        df = r2 - {1'b0, x.q};
        ge = (r2 >= {1'b0, x.q});
        y = x;
        y.rem = ge ? df[REM_W-1:0] : r2[REM_W-1:0];
        y.low = {x.low[QUO_W-2:0], 1'b0};
        y.quo = {x.quo[QUO_W-2:0], ge};
        return y;
    endfunction

endpackage

FILE: rtl/vpp_in_if.sv
// Input channel of the projection block: valid/ready plus nine components.
// Uses no package.
interface vpp_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;

    modport source (output valid, vx, vy, vz, ax, ay, az, bx, by, bz, input ready);
    modport sink   (input valid, vx, vy, vz, ax, ay, az, bx, by, bz, output ready);
endinterface

FILE: rtl/vpp_out_if.sv
// Output channel of the projection block: valid/ready plus result item.
// Uses no package.
interface vpp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic               degenerate;

    modport source (output valid, px, py, pz, degenerate, input ready);
    modport sink   (input valid, px, py, pz, degenerate, output ready);
endinterface

FILE: rtl/vpp_front.sv
// Front end: cross product, magnitude, shift search and normalization.
// Five register stages. Depends on vpp_pkg.
module vpp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  vpp_pkg::t_in_item i_item,
    output logic              o_vld,
    output vpp_pkg::t_ns_item o_item
);

    logic [4:0] r_vld;

    logic signed [vpp_pkg::N_W-1:0] r1_p [6];
    logic [2:0][vpp_pkg::Q_W-1:0]   r1_v;

    logic signed [vpp_pkg::N_W-1:0] r2_n [3];
    logic [2:0][vpp_pkg::Q_W-1:0]   r2_v;

    logic [vpp_pkg::N_W-1:0]        n3_mag [3];
    logic [vpp_pkg::N_W-1:0]        r3_mag [3];
    logic [2:0]                     r3_neg;
    logic [vpp_pkg::N_W-1:0]        r3_or;
    logic                           r3_degen;
    logic [2:0][vpp_pkg::Q_W-1:0]   r3_v;

    logic [vpp_pkg::S_W-1:0]        n4_s;
    logic [vpp_pkg::S_W-1:0]        r4_s;
    logic [vpp_pkg::N_W-1:0]        r4_mag [3];
    logic [2:0]                     r4_neg;
    logic                           r4_degen;
    logic [2:0][vpp_pkg::Q_W-1:0]   r4_v;

    vpp_pkg::t_ns_item              n5_item;
    vpp_pkg::t_ns_item              r5_item;

    // valid bits move with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    // stage 1: the six cross products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p[0] <= 64'(i_item.ay * i_item.bz);
            r1_p[1] <= 64'(i_item.az * i_item.by);
            r1_p[2] <= 64'(i_item.az * i_item.bx);
            r1_p[3] <= 64'(i_item.ax * i_item.bz);
            r1_p[4] <= 64'(i_item.ax * i_item.by);
            r1_p[5] <= 64'(i_item.ay * i_item.bx);
            r1_v    <= {i_item.vz, i_item.vy, i_item.vx};
        end
    end

    // stage 2: normal n = a x b
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_n[0] <= r1_p[0] - r1_p[1];
            r2_n[1] <= r1_p[2] - r1_p[3];
            r2_n[2] <= r1_p[4] - r1_p[5];
            r2_v    <= r1_v;
        end
    end

    // stage 3: magnitudes and their OR (same bit length as the max)
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n3_mag[i] = r2_n[i][vpp_pkg::N_W-1] ? 64'(-r2_n[i]) : 64'(r2_n[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r3_mag[i] <= n3_mag[i];
                r3_neg[i] <= r2_n[i][vpp_pkg::N_W-1];
            end
            r3_or    <= n3_mag[0] | n3_mag[1] | n3_mag[2];
            r3_degen <= (r2_n[0] == '0) && (r2_n[1] == '0) && (r2_n[2] == '0);
            r3_v     <= r2_v;
        end
    end

    // stage 4: shift that brings the largest magnitude below 2^30
    always_comb begin
        n4_s = '0;
        for (int i = vpp_pkg::T_W; i < vpp_pkg::N_W; i++) begin
            if (r3_or[i]) begin
                n4_s = vpp_pkg::S_W'(i - (vpp_pkg::T_W - 1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_s     <= n4_s;
            r4_mag   <= r3_mag;
            r4_neg   <= r3_neg;
            r4_degen <= r3_degen;
            r4_v     <= r3_v;
        end
    end

    // stage 5: truncate the magnitudes
    always_comb begin
        n5_item.v     = r4_v;
        n5_item.nneg  = r4_neg;
        n5_item.degen = r4_degen;
        for (int i = 0; i < 3; i++) begin
            n5_item.t[i] = vpp_pkg::T_W'(r4_mag[i] >> r4_s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_item <= n5_item;
        end
    end

    assign o_vld  = r_vld[4];
    assign o_item = r5_item;

endmodule

FILE: rtl/vpp_dot.sv
// Dot products v.n' and n'.n', then the numerators |n'_i| * |v.n'|.
// Five register stages. Depends on vpp_pkg.
module vpp_dot (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  vpp_pkg::t_ns_item i_item,
    output logic              o_vld,
    output vpp_pkg::t_div_in  o_item [3]
);

    logic [4:0] r_vld;

    logic signed [vpp_pkg::PR_W-1:0] r6_pr [3];
    logic [vpp_pkg::SQ_W-1:0]        r6_sq [3];
    vpp_pkg::t_ns_item               r6_item;

    logic signed [vpp_pkg::D_W-1:0]  n7_d;
    logic [vpp_pkg::QS_W-1:0]        n7_q;
    logic signed [vpp_pkg::D_W-1:0]  r7_d;
    logic [vpp_pkg::QS_W-1:0]        r7_q;
    vpp_pkg::t_ns_item               r7_item;

    logic [vpp_pkg::DM_W-1:0]        r8_dmag;
    logic [2:0]                      r8_neg;
    logic [vpp_pkg::QS_W-1:0]        r8_q;
    vpp_pkg::t_ns_item               r8_item;

    logic [vpp_pkg::PL_W-1:0]        r9_pl [3];
    logic [vpp_pkg::PH_W-1:0]        r9_ph [3];
    logic [2:0]                      r9_neg;
    logic [vpp_pkg::QS_W-1:0]        r9_q;
    logic [2:0][vpp_pkg::Q_W-1:0]    r9_v;
    logic                            r9_degen;

    vpp_pkg::t_div_in                r10_item [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    // stage 6: v_i * |n'_i| and |n'_i|^2
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r6_pr[i] <= 63'($signed(i_item.v[i]) * $signed({1'b0, i_item.t[i]}));
                r6_sq[i] <= 60'(i_item.t[i] * i_item.t[i]);
            end
            r6_item <= i_item;
        end
    end

    // stage 7: sums, sign of n' applied to the products
    always_comb begin
        n7_d = '0;
        n7_q = '0;
        for (int i = 0; i < 3; i++) begin
            n7_d = n7_d + (r6_item.nneg[i] ? -64'(r6_pr[i]) : 64'(r6_pr[i]));
            n7_q = n7_q + 62'(r6_sq[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_d    <= n7_d;
            r7_q    <= n7_q;
            r7_item <= r6_item;
        end
    end

    // stage 8: |d| and the sign of each correction term
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r8_dmag <= r7_d[vpp_pkg::D_W-1] ? vpp_pkg::DM_W'(-r7_d) : vpp_pkg::DM_W'(r7_d);
            for (int i = 0; i < 3; i++) begin
                r8_neg[i] <= r7_item.nneg[i] ^ r7_d[vpp_pkg::D_W-1];
            end
            r8_q    <= r7_q;
            r8_item <= r7_item;
        end
    end

    // stage 9: partial products of |n'_i| * |d|, split at 32 bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r9_pl[i] <= 62'(r8_item.t[i] * r8_dmag[vpp_pkg::HALF_W-1:0]);
                r9_ph[i] <= 61'(r8_item.t[i] * r8_dmag[vpp_pkg::DM_W-1:vpp_pkg::HALF_W]);
            end
            r9_neg   <= r8_neg;
            r9_q     <= r8_q;
            r9_v     <= r8_item.v;
            r9_degen <= r8_item.degen;
        end
    end

    // stage 10: combine partial products into the dividends
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r10_item[i].num   <= 93'(r9_pl[i]) + {r9_ph[i], {vpp_pkg::HALF_W{1'b0}}};
                r10_item[i].q     <= r9_q;
                r10_item[i].v     <= r9_v[i];
                r10_item[i].neg   <= r9_neg[i];
                r10_item[i].degen <= r9_degen;
            end
        end
    end

    assign o_vld  = r_vld[4];
    assign o_item = r10_item;

endmodule

FILE: rtl/vpp_div.sv
// One component: pipelined restoring divide (one quotient bit per stage),
// rounding, subtraction from v and saturation. Depends on vpp_pkg.
module vpp_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  vpp_pkg::t_div_in i_item,
    output logic             o_vld,
    output vpp_pkg::t_q16    o_p,
    output logic             o_degen
);

    localparam int NSTEP = vpp_pkg::QUO_W;

    vpp_pkg::t_div_stg            w_init;
    vpp_pkg::t_div_stg            n_stg [NSTEP];
    vpp_pkg::t_div_stg            r_stg [NSTEP];
    logic [NSTEP-1:0]             r_svld;

    logic [vpp_pkg::C_W-1:0]      n_c;
    logic [vpp_pkg::C_W-1:0]      r_c;
    logic signed [vpp_pkg::Q_W-1:0] r_rv;
    logic                         r_rneg;
    logic                         r_rdeg;
    logic                         r_rvld;

    logic signed [vpp_pkg::SUM_W-1:0] n_sum;
    vpp_pkg::t_q16                n_p;
    vpp_pkg::t_q16                r_p;
    logic                         r_fdeg;
    logic                         r_fvld;

    // upper dividend bits are below q, so the quotient fits in NSTEP bits
    always_comb begin
        w_init.rem   = vpp_pkg::REM_W'(i_item.num[vpp_pkg::NUM_W-1:NSTEP]);
        w_init.low   = i_item.num[NSTEP-1:0];
        w_init.quo   = '0;
        w_init.q     = i_item.q;
        w_init.v     = i_item.v;
        w_init.neg   = i_item.neg;
        w_init.degen = i_item.degen;
    end

    // divide pipeline, one step per stage
    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        if (k == 0) begin : g_first
            assign n_stg[k] = vpp_pkg::div_step(w_init);
        end else begin : g_next
            assign n_stg[k] = vpp_pkg::div_step(r_stg[k-1]);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_svld <= '0;
            r_rvld <= 1'b0;
            r_fvld <= 1'b0;
        end else if (i_en) begin
            r_svld <= {r_svld[NSTEP-2:0], i_vld};
            r_rvld <= r_svld[NSTEP-1];
            r_fvld <= r_rvld;
        end
    end

    // round to nearest, ties away from zero
    always_comb begin
        n_c = vpp_pkg::C_W'(r_stg[NSTEP-1].quo)
            + vpp_pkg::C_W'(r_stg[NSTEP-1].rem >= (r_stg[NSTEP-1].q - r_stg[NSTEP-1].rem));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c    <= n_c;
            r_rv   <= r_stg[NSTEP-1].v;
            r_rneg <= r_stg[NSTEP-1].neg;
            r_rdeg <= r_stg[NSTEP-1].degen;
        end
    end

    // p = v - c with the sign of c, saturated; degenerate plane gives zero
    always_comb begin
        n_sum = r_rneg ? (36'(r_rv) + $signed(36'(r_c))) : (36'(r_rv) - $signed(36'(r_c)));
        if (r_rdeg) begin
            n_p = '0;
        end else if (!n_sum[vpp_pkg::SUM_W-1] && (|n_sum[vpp_pkg::SUM_W-2:vpp_pkg::Q_W-1])) begin
            n_p = {1'b0, {(vpp_pkg::Q_W-1){1'b1}}};
        end else if (n_sum[vpp_pkg::SUM_W-1] && !(&n_sum[vpp_pkg::SUM_W-2:vpp_pkg::Q_W-1])) begin
            n_p = {1'b1, {(vpp_pkg::Q_W-1){1'b0}}};
        end else begin
            n_p = n_sum[vpp_pkg::Q_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p    <= n_p;
            r_fdeg <= r_rdeg;
        end
    end

    assign o_vld   = r_fvld;
    assign o_p     = r_p;
    assign o_degen = r_fdeg;

endmodule

FILE: rtl/vector_plane_projection.sv
// Top level of the vector plane projection block: front end, dot products,
// three divider lanes and the output register with skid. Depends on vpp_pkg,
// vpp_in_if, vpp_out_if, vpp_front, vpp_dot, vpp_div and the assertion header.
//
// Usage:
//   i_in carries v, a, b (signed Q16.16); o_out carries the projection of v onto
//   the plane spanned by a and b, plus a degenerate flag when a x b is zero
//   (then the components are zero). Components saturate to the Q16.16 range.
//   Items are accepted when valid and ready are both high; one result per item,
//   in order.
//   Throughput: one item per cycle while the skid register is empty. The path
//   from acceptance to o_out.valid runs through ten stages of cross product,
//   normalization and dot products, the 33-stage divide pipeline (one quotient
//   bit per stage), and the rounding, saturation and output registers.
//   A stalled receiver holds the current result; the next finished result moves
//   into a skid register, and from the following cycle the whole pipeline holds
//   and i_in.ready is low until the receiver takes a result.
//   Reset (i_rst_n low, synchronous) empties the pipeline; no item is lost
//   or repeated across a stall.
`include "vector_plane_projection_assert.svh"

module vector_plane_projection (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vpp_in_if.sink     i_in,
    vpp_out_if.source  o_out
);

    logic                  w_en;
    vpp_pkg::t_in_item     w_in;

    logic                  w_fvld;
    vpp_pkg::t_ns_item     w_ns;
    logic                  w_dvld;
    vpp_pkg::t_div_in      w_div_in [3];
    logic [2:0]            w_lvld;
    vpp_pkg::t_q16         w_p [3];
    logic [2:0]            w_deg;
    vpp_pkg::t_out_item    w_res;

    logic                  w_fire;
    logic                  r_out_vld;
    logic                  n_out_vld;
    vpp_pkg::t_out_item    r_out;
    vpp_pkg::t_out_item    n_out;
    logic                  r_skid_vld;
    logic                  n_skid_vld;
    vpp_pkg::t_out_item    r_skid;
    vpp_pkg::t_out_item    n_skid;

    // pipeline advances while the skid register is free
    assign w_en       = !r_skid_vld;
    assign i_in.ready = w_en;

    assign w_in = '{vx: i_in.vx, vy: i_in.vy, vz: i_in.vz,
                    ax: i_in.ax, ay: i_in.ay, az: i_in.az,
                    bx: i_in.bx, by: i_in.by, bz: i_in.bz};

    vpp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in.valid),
        .i_item  (w_in),
        .o_vld   (w_fvld),
        .o_item  (w_ns)
    );

    vpp_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_fvld),
        .i_item  (w_ns),
        .o_vld   (w_dvld),
        .o_item  (w_div_in)
    );

    // one divider lane per component
    for (genvar g = 0; g < 3; g++) begin : g_lane
        vpp_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_dvld),
            .i_item  (w_div_in[g]),
            .o_vld   (w_lvld[g]),
            .o_p     (w_p[g]),
            .o_degen (w_deg[g])
        );
    end

    assign w_res = '{px: w_p[0], py: w_p[1], pz: w_p[2], degenerate: w_deg[0]};

    // output register with one skid entry
    assign w_fire = r_out_vld && o_out.ready;

    always_comb begin
        n_out_vld  = r_out_vld;
        n_out      = r_out;
        n_skid_vld = r_skid_vld;
        n_skid     = r_skid;
        if (r_skid_vld) begin
            if (w_fire) begin
                n_out      = r_skid;
                n_skid_vld = 1'b0;
            end
        end else if (w_lvld[0]) begin
            if (!r_out_vld || w_fire) begin
                n_out     = w_res;
                n_out_vld = 1'b1;
            end else begin
                n_skid     = w_res;
                n_skid_vld = 1'b1;
            end
        end else if (w_fire) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.px         = r_out.px;
    assign o_out.py         = r_out.py;
    assign o_out.pz         = r_out.pz;
    assign o_out.degenerate = r_out.degenerate;

    // checks
    `VPP_ASSERT_ALWAYS(a_lanes_aligned, i_clk, i_rst_n, (w_lvld[0] == w_lvld[1]) && (w_lvld[1] == w_lvld[2]), "divider lanes out of step")
    `VPP_ASSERT_ALWAYS(a_skid_behind_out, i_clk, i_rst_n, !r_skid_vld || r_out_vld, "skid holds an item while output is empty")
    `VPP_ASSERT_IMPL(a_degen_zero, i_clk, i_rst_n, r_out_vld && r_out.degenerate, (r_out.px == '0) && (r_out.py == '0) && (r_out.pz == '0), "degenerate result not zero")
    `VPP_ASSERT_NEXT(a_skid_kept, i_clk, i_rst_n, r_skid_vld && !o_out.ready, r_skid_vld, "skid item dropped during stall")

endmodule

FILE: tb/sv/vector_plane_projection_tb.sv
// Testbench for vector_plane_projection: drives v, a, b items and checks each
// projection against a bit-exact fixed-point predictor. Depends on vpp_pkg,
// vpp_in_if, vpp_out_if and the block itself.
module vector_plane_projection_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   idle_cycles;
    int   hold_off;        // cycles the receiver must still stall
    bit   gaps_on;         // sender gaps enabled

    vpp_in_if  in_ch();
    vpp_out_if out_ch();

    vector_plane_projection dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    vpp_pkg::t_out_item projection_q[$];

    // clock
    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // rounded magnitude quotient, ties away from zero
    function automatic logic [63:0] div_nearest(logic [127:0] num, logic [63:0] den);
        logic [127:0] quo;
        logic [127:0] rem;
        quo = num / den;
        rem = num % den;
        if (rem >= den - rem) quo = quo + 1;
        return quo[63:0];
    endfunction

    function automatic logic signed [31:0] sat_q16(logic signed [127:0] x);
        if (x > 128'sd2147483647) return 32'sh7fffffff;
        if (x < -128'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    // expected projection of v onto the plane spanned by a and b
    function automatic vpp_pkg::t_out_item project(vpp_pkg::t_in_item it);
        logic signed [63:0] v[3], a[3], b[3], n[3], ns[3];
        logic [63:0]        mag, mx, q, dmag, c;
        logic signed [63:0] d;
        logic signed [127:0] ci;
        int                 sh;
        vpp_pkg::t_out_item r;
        v[0] = it.vx; v[1] = it.vy; v[2] = it.vz;
        a[0] = it.ax; a[1] = it.ay; a[2] = it.az;
        b[0] = it.bx; b[1] = it.by; b[2] = it.bz;
        n[0] = a[1] * b[2] - a[2] * b[1];
        n[1] = a[2] * b[0] - a[0] * b[2];
        n[2] = a[0] * b[1] - a[1] * b[0];
        r = '0;
        if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            mag = n[i] < 0 ? -n[i] : n[i];
            if (mag > mx) mx = mag;
        end
        sh = 0;
        while ((mx >> sh) >= 64'd1 << 30) sh++;
        d = 0;
        q = 0;
        for (int i = 0; i < 3; i++) begin
            mag = (n[i] < 0 ? -n[i] : n[i]) >> sh;
            ns[i] = n[i] < 0 ? -$signed(mag) : $signed(mag);
            d += v[i] * ns[i];
            q += mag * mag;
        end
        dmag = d < 0 ? -d : d;
        for (int i = 0; i < 3; i++) begin
            mag = ns[i] < 0 ? -ns[i] : ns[i];
            c = div_nearest({64'd0, mag} * {64'd0, dmag}, q);
            ci = $signed({64'd0, c});
            if ((ns[i] < 0) != (d < 0)) ci = -ci;
            ci = $signed({{64{v[i][63]}}, v[i]}) - ci;
            case (i)
                0: r.px = sat_q16(ci);
                1: r.py = sat_q16(ci);
                default: r.pz = sat_q16(ci);
            endcase
        end
        return r;
    endfunction

    // send one item, with a random gap before it when gaps are on
    task automatic send_item(vpp_pkg::t_in_item it);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.vx <= it.vx; in_ch.vy <= it.vy; in_ch.vz <= it.vz;
        in_ch.ax <= it.ax; in_ch.ay <= it.ay; in_ch.az <= it.az;
        in_ch.bx <= it.bx; in_ch.by <= it.by; in_ch.bz <= it.bz;
        do @(posedge i_clk); while (!in_ch.ready);
        projection_q.push_back(project(it));
    endtask

    task automatic finish_sending();
        in_ch.valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_q16();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            2: return $signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000;
            3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            4: return $signed($urandom_range(0, 8)) - 4;
            default: return $signed($urandom_range(0, 32'hfffffff)) - 32'sh8000000;
        endcase
    endfunction

    function automatic vpp_pkg::t_in_item make_item(logic signed [31:0] vx, vy, vz,
                                                    logic signed [31:0] ax, ay, az,
                                                    logic signed [31:0] bx, by, bz);
        vpp_pkg::t_in_item it;
        it.vx = vx; it.vy = vy; it.vz = vz;
        it.ax = ax; it.ay = ay; it.az = az;
        it.bx = bx; it.by = by; it.bz = bz;
        return it;
    endfunction

    // extremes, degenerate planes, vectors normal to the plane
    task automatic test_directed();
        localparam logic signed [31:0] MAXV = 32'sh7fffffff;
        localparam logic signed [31:0] MINV = 32'sh80000000;
        localparam logic signed [31:0] ONE  = 32'sh10000;
        gaps_on = 1'b0;
        send_item(make_item(ONE, 2*ONE, 3*ONE, ONE, 0, 0, 0, ONE, 0));
        send_item(make_item(0, 0, 5*ONE, ONE, 0, 0, 0, ONE, 0));
        send_item(make_item(ONE, ONE, ONE, 0, 0, 0, ONE, 0, 0));
        send_item(make_item(ONE, ONE, ONE, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE));
        send_item(make_item(MAXV, MINV, MAXV, 0, 0, 0, 0, 0, 0));
        send_item(make_item(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MINV, MINV, MINV));
        send_item(make_item(MINV, MINV, MINV, MAXV, 0, 0, 0, MAXV, 0));
        send_item(make_item(MAXV, MAXV, MAXV, MINV, MINV, 0, MAXV, MINV, MAXV));
        send_item(make_item(MINV, MAXV, MINV, MINV, MAXV, MINV, MAXV, MAXV, MINV));
        send_item(make_item(MAXV, MINV, MAXV, MINV, MINV, MINV, MINV, MAXV, MAXV));
        send_item(make_item(-1, -1, -1, 1, 0, 0, 0, 1, 0));
        send_item(make_item(MAXV, MAXV, MINV, 1, 2, 3, 4, 5, 7));
        send_item(make_item(3*ONE, -4*ONE, ONE, ONE, ONE, 0, -ONE, ONE, 0));
        // v along a x b = (1,-1,2)
        send_item(make_item(ONE, -ONE, 2*ONE, ONE, ONE, 0, 0, 2*ONE, ONE));
        send_item(make_item(32'sh12345678, 32'sh9abcdef0, 32'sh0fedcba9,
                            -32'sh10000, 32'sh7fff0000, 3, 32'sh55555555, -7, MINV));
        finish_sending();
    endtask

    task automatic test_random(int count);
        logic signed [31:0] k;
        vpp_pkg::t_in_item it;
        gaps_on = 1'b1;
        for (int i = 0; i < count; i++) begin
            it = make_item(rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16(),
                           rand_q16(), rand_q16(), rand_q16(), rand_q16());
            case ($urandom_range(0, 9))
                0: begin  // b parallel to a
                    k = $signed($urandom_range(0, 6)) - 3;
                    it.bx = it.ax * k; it.by = it.ay * k; it.bz = it.az * k;
                end
                1: begin  // v normal to the plane of the axes
                    it.ax = rand_q16(); it.ay = 0; it.az = 0;
                    it.bx = 0; it.by = rand_q16(); it.bz = 0;
                    it.vx = 0; it.vy = 0;
                end
                default: ;
            endcase
            send_item(it);
            // burst boundary: occasional longer pause
            if ($urandom_range(0, 40) == 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(5, 30)) @(posedge i_clk);
            end
        end
        finish_sending();
    endtask

    // receiver holds off long while the sender keeps offering
    task automatic test_backpressure();
        hold_off = 200;
        test_random(120);
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_off <= 0;
        end else if (hold_off > 0) begin
            out_ch.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 3) == 0);
        end
    end

    // result checker and watchdog
    always @(posedge i_clk) begin
        vpp_pkg::t_out_item exp_r;
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (projection_q.size() == 0) begin
                    $error("result with no item pending");
                    fail_count++;
                end else begin
                    exp_r = projection_q.pop_front();
                    if (out_ch.px !== exp_r.px) begin
                        $error("px expected %0d got %0d", exp_r.px, out_ch.px);
                        fail_count++;
                    end
                    if (out_ch.py !== exp_r.py) begin
                        $error("py expected %0d got %0d", exp_r.py, out_ch.py);
                        fail_count++;
                    end
                    if (out_ch.pz !== exp_r.pz) begin
                        $error("pz expected %0d got %0d", exp_r.pz, out_ch.pz);
                        fail_count++;
                    end
                    if (out_ch.degenerate !== exp_r.degenerate) begin
                        $error("degenerate expected %0b got %0b",
                               exp_r.degenerate, out_ch.degenerate);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin
        fail_count  = 0;
        idle_cycles = 0;
        gaps_on     = 1'b0;
        i_rst_n     = 1'b0;
        in_ch.valid = 1'b0;
        {in_ch.vx, in_ch.vy, in_ch.vz} = '0;
        {in_ch.ax, in_ch.ay, in_ch.az} = '0;
        {in_ch.bx, in_ch.by, in_ch.bz} = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(1210);
        while (projection_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && projection_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
